// ===== sv/b64_pkg.sv =====
// b64_pkg: shared types, constants and the sextet to ascii mapping for the
// base64 stream encoder. No dependencies.
package b64_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [6:0] PAD_CHAR = 7'h3d;

  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  typedef struct packed {
    logic [23:0] bits;
    pad_t        npad;
    logic        fin;
  } group_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      sextet_char = v7 + 7'd65;
    end else if (v < 6'd52) begin
      sextet_char = v7 + 7'd71;
    end else if (v < 6'd62) begin
      sextet_char = v7 - 7'd4;
    end else if (v == 6'd62) begin
      sextet_char = 7'h2b;
    end else begin
      sextet_char = 7'h2f;
    end
  endfunction

endpackage

// ===== sv/b64_front.sv =====
// b64_front: accepts input bytes, holds up to two pending bytes and forms
// complete or final groups for the queue. Depends on b64_pkg.
module b64_front import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  q_status_t  q_status,
  output logic       push,
  output group_t     push_grp
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pend_nxt          = pend_r;
    cnt_nxt           = cnt_r;
    push              = 1'b0;
    push_grp.fin      = in_final_byte;
    push_grp.bits     = {pend_r, in_data_byte};
    push_grp.npad     = PAD_NONE;
    case (cnt_r)
      2'd0: begin
        push_grp.bits = {in_data_byte, 16'h0000};
        push_grp.npad = PAD_TWO;
      end
      2'd1: begin
        push_grp.bits = {pend_r[15:8], in_data_byte, 8'h00};
        push_grp.npad = PAD_ONE;
      end
      default: begin
        push_grp.bits = {pend_r, in_data_byte};
        push_grp.npad = PAD_NONE;
      end
    endcase
    if (accept) begin
      if (push_grp.npad != PAD_NONE && !in_final_byte) begin
        if (cnt_r == 2'd0) begin
          pend_nxt = {in_data_byte, 8'h00};
        end else begin
          pend_nxt = {pend_r[15:8], in_data_byte};
        end
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        push     = 1'b1;
        pend_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== sv/b64_queue.sv =====
// b64_queue: short group queue between the front and back parts.
// Depends on b64_pkg.
module b64_queue import b64_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  group_t    push_grp,
  input  logic      pop,
  output q_status_t q_status,
  output group_t    head_grp
);

  group_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    cnt_r;

  assign q_status.full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_status.valid = (cnt_r != '0);
  assign head_grp       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== sv/b64_back.sv =====
// b64_back: takes groups from the queue and sends four characters per group
// through a registered output stage. Depends on b64_pkg.
module b64_back import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_status,
  input  group_t     head_grp,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic       out_run_last,
  output logic       out_message_last
);

  group_t     grp_r, grp_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       run_last_r, run_last_nxt;
  logic       msg_last_r, msg_last_nxt;
  logic       slot_free, adv;
  logic [5:0] sextet;
  logic       is_pad;

  assign slot_free = !out_valid_r || !out_stall;
  assign adv       = busy_r && slot_free;

  always_comb begin
    case (idx_r)
      2'd0:    sextet = grp_r.bits[23:18];
      2'd1:    sextet = grp_r.bits[17:12];
      2'd2:    sextet = grp_r.bits[11:6];
      default: sextet = grp_r.bits[5:0];
    endcase
    is_pad = ((idx_r == 2'd3) && (grp_r.npad != PAD_NONE)) ||
             ((idx_r == 2'd2) && (grp_r.npad == PAD_TWO));
  end

  always_comb begin
    grp_nxt       = grp_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    run_last_nxt  = run_last_r;
    msg_last_nxt  = msg_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      char_nxt      = is_pad ? PAD_CHAR : sextet_char(sextet);
      run_last_nxt  = (idx_r == 2'd3);
      msg_last_nxt  = (idx_r == 2'd3) && grp_r.fin;
      if (idx_r == 2'd3) begin
        busy_nxt = q_status.valid;
        grp_nxt  = head_grp;
        pop      = q_status.valid;
        idx_nxt  = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end else if (!busy_r && q_status.valid) begin
      busy_nxt = 1'b1;
      grp_nxt  = head_grp;
      pop      = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    grp_r      <= grp_nxt;
    char_r     <= char_nxt;
    run_last_r <= run_last_nxt;
    msg_last_r <= msg_last_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_code    = char_r;
  assign out_run_last     = run_last_r;
  assign out_message_last = msg_last_r;

endmodule

// ===== sv/base64_stream_encoder.sv =====
// base64_stream_encoder: top level joining front, queue and back parts.
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
//
// Encodes a byte stream into standard base64 characters with '=' padding,
// one byte per input transaction and one character per output transaction.
// A byte that completes a group of three, or carries the final flag, yields
// four characters; other bytes are held and yield none. Bytes are taken one
// per cycle while the two-entry group queue has room; the sustained rate is
// set by the character serialiser in the back part, which sends one
// character per cycle while out_stall is low, four characters per group.
// A group's last byte is written to the queue, then taken into the back
// part's group register and from there into the registered output.
module base64_stream_encoder import b64_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic       out_run_last,
  output logic       out_message_last
);

  q_status_t q_status;
  logic      push, pop;
  group_t    push_grp, head_grp;

  b64_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_status      (q_status),
    .push          (push),
    .push_grp      (push_grp)
  );

  b64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .q_status (q_status),
    .head_grp (head_grp)
  );

  b64_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .head_grp         (head_grp),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_code    (out_char_code),
    .out_run_last     (out_run_last),
    .out_message_last (out_message_last)
  );

endmodule

// ===== sv/b64_checker.sv =====
// b64_checker: port-level assertions for the base64 stream encoder, bound
// to the top level. Depends on base64_stream_encoder.
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char_code,
  input logic       out_run_last,
  input logic       out_message_last
);

  // stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) &&
    $stable(out_run_last) && $stable(out_message_last))
    else $error("stalled output transaction changed");

  // message end only on the last character of a group
  a_msg_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_last |-> out_run_last)
    else $error("message_last without run_last");

  // only alphabet characters or padding
  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code >= 7'h41 && out_char_code <= 7'h5a) ||
    (out_char_code >= 7'h61 && out_char_code <= 7'h7a) ||
    (out_char_code >= 7'h30 && out_char_code <= 7'h39) ||
    out_char_code == 7'h2b || out_char_code == 7'h2f || out_char_code == 7'h3d)
    else $error("character outside base64 alphabet");

  // padding only ends a final group
  a_pad_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last && out_char_code == 7'h3d |-> out_message_last)
    else $error("padding in a group that is not final");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_char_code    (out_char_code),
  .out_run_last     (out_run_last),
  .out_message_last (out_message_last)
);

// ===== bench/tb_base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// tb_base64_stream_encoder: self-checking bench for the base64 stream encoder, a directed
// table then random messages, each character checked against row text or an in-bench encoder.
// Depends on b64_pkg and base64_stream_encoder.
module tb_base64_stream_encoder;
  import b64_pkg::*;

  localparam int ITEM_TARGET  = 310;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [8*64-1:0] B64_ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                              "abcdefghijklmnopqrstuvwxyz",
                                              "0123456789+/"};

  typedef struct packed {
    logic [6:0] code;
    logic       run_last;
    logic       msg_last;
  } b64_char_t;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [31:0] text;
  } table_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_char_code;
  logic       out_run_last;
  logic       out_message_last;

  logic [15:0]  held_bytes;
  logic [1:0]   held_count;
  b64_char_t    enc_chars [4];
  int           enc_count;
  b64_char_t    expected_chars [$];
  table_row_t   directed_rows [$];
  int           mismatch_count = 0;
  int           bytes_sent = 0;
  int           messages_sent = 0;
  int           chars_checked = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           stretch_left = 0;
  stall_mode_t  stall_mode = STALL_NONE;

  base64_stream_encoder uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    return B64_ALPHABET[8 * (63 - v) +: 7];
  endfunction

  // updates the held group and leaves the characters this byte yields in enc_chars
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [23:0] grp;
    logic [1:0]  cnt;
    cnt = (held_count == 2'd3) ? 2'd2 : held_count;
    enc_count = 0;
    if (cnt < 2 && !fin) begin
      if (cnt == 0) held_bytes = {b, 8'h00};
      else held_bytes[7:0] = b;
      held_count = cnt + 2'd1;
    end else begin
      case (cnt)
        2'd0: grp = {b, 16'h0000};
        2'd1: grp = {held_bytes[15:8], b, 8'h00};
        default: grp = {held_bytes, b};
      endcase
      for (int k = 0; k < 4; k++) begin
        enc_chars[k].code     = sextet_to_ascii(grp[23 - 6 * k -: 6]);
        enc_chars[k].run_last = (k == 3);
        enc_chars[k].msg_last = fin && (k == 3);
      end
      if (cnt == 0) enc_chars[2].code = PAD_CHAR;
      if (cnt < 2) enc_chars[3].code = PAD_CHAR;
      enc_count  = 4;
      held_bytes = '0;
      held_count = '0;
    end
  endtask

  task automatic add_row(input logic [7:0] d, input logic f, input logic t,
                         input logic [31:0] txt);
    table_row_t r;
    r.data  = d;
    r.fin   = f;
    r.typed = t;
    r.text  = txt;
    directed_rows.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic fin, input logic typed,
                           input logic [31:0] text);
    int        gap;
    b64_char_t c;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_data_byte  = d;
    in_final_byte = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_byte(d, fin);
    for (int k = 0; k < enc_count; k++) begin
      if (typed) begin
        c.code     = text[24 - 8 * k +: 7];
        c.run_last = (k == 3);
        c.msg_last = fin && (k == 3);
      end else begin
        c = enc_chars[k];
      end
      expected_chars.push_back(c);
    end
    bytes_sent++;
    if (fin) messages_sent++;
    burst_left--;
  endtask

  // receiver stall pattern, changes character every stretch
  always @(negedge clk) begin
    if (stretch_left == 0) begin
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      stretch_left = $urandom_range(16, 80);
    end
    stretch_left--;
    case (stall_mode)
      STALL_NONE: out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = (cycle_count % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    b64_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got code %02h run_last %0b %s %0b",
                 $time, out_char_code, out_run_last, "message_last", out_message_last);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char_code !== want.code) begin
          $display("%0t: char_code expected %02h got %02h", $time, want.code, out_char_code);
          mismatch_count++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b got %0b", $time, want.run_last, out_run_last);
          mismatch_count++;
        end
        if (out_message_last !== want.msg_last) begin
          $display("%0t: message_last expected %0b got %0b", $time, want.msg_last,
                   out_message_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d characters outstanding", $time,
               expected_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_final_byte = 1'b0;
    held_bytes    = '0;
    held_count    = '0;

    add_row(8'h00, 1'b1, 1'b1, "AA==");
    add_row(8'hff, 1'b1, 1'b1, "/w==");
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b1, 1'b1, "AAA=");
    add_row(8'hff, 1'b0, 1'b0, 32'h0);
    add_row(8'hff, 1'b1, 1'b1, "//8=");
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b1, "AAAA");
    add_row(8'hff, 1'b0, 1'b0, 32'h0);
    add_row(8'hff, 1'b0, 1'b0, 32'h0);
    add_row(8'hff, 1'b1, 1'b1, "////");
    add_row(8'h4d, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b0, 1'b0, 32'h0);
    add_row(8'h6e, 1'b0, 1'b0, 32'h0);
    add_row(8'hfb, 1'b0, 1'b0, 32'h0);
    add_row(8'hef, 1'b0, 1'b0, 32'h0);
    add_row(8'hbe, 1'b1, 1'b0, 32'h0);
    add_row(8'h4d, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b1, 1'b0, 32'h0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].text);

    // random messages, mostly short, now and then a long one
    while (bytes_sent < ITEM_TARGET) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      for (int j = 0; j < len; j++)
        send_byte(8'($urandom_range(0, 255)), j == len - 1, 1'b0, 32'h0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes in %0d messages, %0d characters compared",
             bytes_sent, messages_sent, chars_checked);
    $display("%0d mismatches seen", mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
